// ----- design/lbf_pkg.sv -----
// shared widths, result codes and size defaults for the longest path block
// no dependencies; used by the interfaces, the top level and the testbench
package lbf_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int MAX_EDGES_DEF    = 1024;

	localparam int VID_W    = 8;
	localparam int WEIGHT_W = 32;
	localparam int DIST_W   = 41;
	localparam int CFG_W    = 9;
	localparam int STATUS_W = 2;
	localparam int EDGE_W   = 2 * VID_W + WEIGHT_W;
	// vertex entry: {unbounded, reached, distance}
	localparam int VENT_W   = DIST_W + 2;

	localparam logic [STATUS_W-1:0] ST_FINITE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNREACH   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNBOUNDED = 2'd2;

	localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

endpackage

// ----- design/lbf_edge_if.sv -----
// valid/ready channel carrying one edge beat
// depends on lbf_pkg for field widths
interface lbf_edge_if;
	logic                                  valid;
	logic                                  ready;
	logic [lbf_pkg::VID_W-1:0]             edge_from;
	logic [lbf_pkg::VID_W-1:0]             edge_to;
	logic signed [lbf_pkg::WEIGHT_W-1:0]   edge_weight;
	logic                                  last_edge;

	modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
	modport sink   (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

// ----- design/lbf_result_if.sv -----
// valid/ready channel carrying one result beat
// depends on lbf_pkg for field widths
interface lbf_result_if;
	logic                                valid;
	logic                                ready;
	logic [lbf_pkg::STATUS_W-1:0]        status;
	logic signed [lbf_pkg::DIST_W-1:0]   longest_distance;

	modport source (output valid, status, longest_distance, input ready);
	modport sink   (input valid, status, longest_distance, output ready);
endinterface

// ----- design/lbf_ram.sv -----
// generic synchronous ram: one write port, two registered read ports
// no dependencies
module lbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                         rdata_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// ----- design/longest_path_bellman_ford.sv -----
// top level: edge loading, bellman-ford longest path sequencer, result register
// depends on lbf_pkg, lbf_edge_if, lbf_result_if and lbf_ram
//
// Edges are taken one beat per cycle while loading and stored in an edge
// ram; a beat with last_edge starts the computation and edges beyond
// MAX_EDGES are dropped. With n the clamped vertex count, the run clears
// the vertex ram, makes n relaxation passes, one marking pass and n
// spreading passes over the stored edges (each edge needs an edge ram read,
// a two-port vertex ram read and a write-back), then reads the target, after
// which one result beat is offered. No edge is accepted during the run; the
// result register lets the next graph load while the last result waits.
module longest_path_bellman_ford #(
	parameter int MAX_VERTICES = lbf_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = lbf_pkg::MAX_EDGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lbf_pkg::CFG_W-1:0]  cfg_wdata,
	lbf_edge_if.sink                   edges,
	lbf_result_if.source               result
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int AW = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
	localparam int EW = $clog2(MAX_EDGES + 1) > 0 ? $clog2(MAX_EDGES + 1) : 1;
	localparam int DW = lbf_pkg::DIST_W;
	localparam int WW = lbf_pkg::WEIGHT_W;
	localparam int IW = lbf_pkg::VID_W;

	typedef enum logic [6:0] {
		S_LOAD     = 7'b0000001,
		S_CLEAR    = 7'b0000010,
		S_RD_EDGE  = 7'b0000100,
		S_RD_VERT  = 7'b0001000,
		S_UPDATE   = 7'b0010000,
		S_FINAL_RD = 7'b0100000,
		S_FINAL    = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		P_RELAX  = 3'b001,
		P_MARK   = 3'b010,
		P_SPREAD = 3'b100
	} pass_t;

	state_t                      state_q;
	pass_t                       pass_q;
	logic [lbf_pkg::CFG_W-1:0]   cfg_q;
	logic [NW-1:0]               n_q;
	logic [NW-1:0]               clr_q;
	logic [NW-1:0]               round_q;
	logic [EW-1:0]               cnt_q;
	logic [EW-1:0]               k_q;
	logic                        res_valid_q;
	logic [lbf_pkg::STATUS_W-1:0] res_status_q;
	logic signed [DW-1:0]        res_dist_q;

	logic                        in_fire;
	logic                        res_load;
	logic [NW-1:0]               n_eff;

	logic                        ewe;
	logic [lbf_pkg::EDGE_W-1:0]  ewdata;
	logic [lbf_pkg::EDGE_W-1:0]  erdata;

	logic                        vwe;
	logic [VW-1:0]               vwaddr;
	logic [lbf_pkg::VENT_W-1:0]  vwdata;
	logic [VW-1:0]               vraddr_a;
	logic [VW-1:0]               vraddr_b;
	logic [lbf_pkg::VENT_W-1:0]  vrd_a;
	logic [lbf_pkg::VENT_W-1:0]  vrd_b;

	logic [IW-1:0]               e_from;
	logic [IW-1:0]               e_to;
	logic signed [WW-1:0]        e_weight;
	logic                        in_range;
	logic                        unb_a;
	logic                        reach_a;
	logic signed [DW-1:0]        dist_a;
	logic                        unb_b;
	logic                        reach_b;
	logic signed [DW-1:0]        dist_b;
	logic signed [DW:0]          cand;
	logic signed [DW:0]          cand_min;
	logic signed [DW:0]          cand_max;
	logic signed [DW-1:0]        cand_clamp;
	logic                        improves;
	logic                        last_k;

	assign in_fire  = edges.valid && edges.ready;
	assign res_load = (state_q == S_FINAL) && (!res_valid_q || result.ready);

	assign edges.ready             = (state_q == S_LOAD);
	assign result.valid            = res_valid_q;
	assign result.status           = res_status_q;
	assign result.longest_distance = res_dist_q;

	// 0 acts as 1, anything above the vertex capacity acts as the capacity
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = NW'(1);
		end else if (cfg_q > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(cfg_q);
		end
	end

	assign ewe    = in_fire && (cnt_q < MAX_EDGES);
	assign ewdata = {edges.edge_from, edges.edge_to, edges.edge_weight};

	lbf_ram #(
		.WIDTH (lbf_pkg::EDGE_W),
		.DEPTH (MAX_EDGES)
	) u_edge_ram (
		.clk     (clk),
		.we      (ewe),
		.waddr   (cnt_q[AW-1:0]),
		.wdata   (ewdata),
		.raddr_a (k_q[AW-1:0]),
		.rdata_a (erdata),
		.raddr_b (k_q[AW-1:0]),
		.rdata_b ()
	);

	assign e_from   = erdata[lbf_pkg::EDGE_W-1 -: IW];
	assign e_to     = erdata[WW +: IW];
	assign e_weight = erdata[WW-1:0];
	assign in_range = (e_from < n_q) && (e_to < n_q);

	assign unb_a   = vrd_a[DW+1];
	assign reach_a = vrd_a[DW];
	assign dist_a  = vrd_a[DW-1:0];
	assign unb_b   = vrd_b[DW+1];
	assign reach_b = vrd_b[DW];
	assign dist_b  = vrd_b[DW-1:0];

	assign cand     = {dist_a[DW-1], dist_a} + {{(DW+1-WW){e_weight[WW-1]}}, e_weight};
	assign cand_max = {lbf_pkg::DIST_MAX[DW-1], lbf_pkg::DIST_MAX};
	assign cand_min = {lbf_pkg::DIST_MIN[DW-1], lbf_pkg::DIST_MIN};
	assign improves = !reach_b || (cand > $signed({dist_b[DW-1], dist_b}));

	always_comb begin
		if (cand > cand_max) begin
			cand_clamp = lbf_pkg::DIST_MAX;
		end else if (cand < cand_min) begin
			cand_clamp = lbf_pkg::DIST_MIN;
		end else begin
			cand_clamp = cand[DW-1:0];
		end
	end

	// read ports: port a reads the target at the end and the edge source otherwise, port b the edge target
	always_comb begin
		if (state_q == S_FINAL_RD || state_q == S_FINAL) begin
			vraddr_a = VW'(n_q - NW'(1));
		end else begin
			vraddr_a = VW'(e_from);
		end
		vraddr_b = VW'(e_to);
	end

	always_comb begin
		vwe    = 1'b0;
		vwaddr = VW'(e_to);
		vwdata = vrd_b;
		case (state_q)
			S_CLEAR: begin
				vwe    = 1'b1;
				vwaddr = clr_q[VW-1:0];
				// the start vertex comes out reached at distance zero
				vwdata = {1'b0, (clr_q == '0), {DW{1'b0}}};
			end
			S_UPDATE: begin
				case (pass_q)
					P_RELAX: begin
						if (in_range && reach_a && improves) begin
							vwe = 1'b1;
							if (!reach_b || cand_clamp > dist_b) begin
								vwdata = {unb_b | (cand > cand_max), 1'b1, cand_clamp};
							end else begin
								vwdata = {unb_b | (cand > cand_max), reach_b, dist_b};
							end
						end
					end
					P_MARK: begin
						if (in_range && reach_a && improves) begin
							vwe    = 1'b1;
							vwdata = {1'b1, reach_b, dist_b};
						end
					end
					P_SPREAD: begin
						if (in_range && reach_a && unb_a) begin
							vwe    = 1'b1;
							vwdata = {1'b1, reach_b, dist_b};
						end
					end
					default: begin
						vwe = 1'b0;
					end
				endcase
			end
			default: begin
				vwe = 1'b0;
			end
		endcase
	end

	lbf_ram #(
		.WIDTH (lbf_pkg::VENT_W),
		.DEPTH (MAX_VERTICES)
	) u_vert_ram (
		.clk     (clk),
		.we      (vwe),
		.waddr   (vwaddr),
		.wdata   (vwdata),
		.raddr_a (vraddr_a),
		.rdata_a (vrd_a),
		.raddr_b (vraddr_b),
		.rdata_b (vrd_b)
	);

	assign last_k = (k_q + EW'(1)) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lbf_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pass_q  <= P_RELAX;
			n_q     <= NW'(1);
			clr_q   <= '0;
			round_q <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (cnt_q < MAX_EDGES) begin
							cnt_q <= cnt_q + EW'(1);
						end
						if (edges.last_edge) begin
							n_q     <= n_eff;
							clr_q   <= '0;
							round_q <= '0;
							k_q     <= '0;
							pass_q  <= P_RELAX;
							state_q <= S_CLEAR;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == n_q - NW'(1)) begin
						state_q <= S_RD_EDGE;
					end
				end
				S_RD_EDGE: begin
					state_q <= S_RD_VERT;
				end
				S_RD_VERT: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_RD_EDGE;
					if (!last_k) begin
						k_q <= k_q + EW'(1);
					end else begin
						k_q <= '0;
						case (pass_q)
							P_RELAX: begin
								if (round_q == n_q - NW'(1)) begin
									round_q <= '0;
									pass_q  <= P_MARK;
								end else begin
									round_q <= round_q + NW'(1);
								end
							end
							P_MARK: begin
								pass_q <= P_SPREAD;
							end
							P_SPREAD: begin
								if (round_q == n_q - NW'(1)) begin
									round_q <= '0;
									state_q <= S_FINAL_RD;
								end else begin
									round_q <= round_q + NW'(1);
								end
							end
							default: begin
								pass_q <= P_RELAX;
							end
						endcase
					end
				end
				S_FINAL_RD: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (res_load) begin
						cnt_q   <= '0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			if (!reach_a) begin
				res_status_q <= lbf_pkg::ST_UNREACH;
				res_dist_q   <= '0;
			end else if (unb_a) begin
				res_status_q <= lbf_pkg::ST_UNBOUNDED;
				res_dist_q   <= '0;
			end else begin
				res_status_q <= lbf_pkg::ST_FINITE;
				res_dist_q   <= dist_a;
			end
		end
	end

	// no vertex write while loading or waiting on the result
	a_no_vwrite_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD || state_q == S_FINAL) |-> !vwe)
		else $error("vertex ram written outside the run");

	// edge index stays below the stored count during the passes
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_EDGE || state_q == S_RD_VERT || state_q == S_UPDATE)
		|-> (k_q < cnt_q))
		else $error("edge index past stored count");

	// round counter stays below the vertex count
	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (round_q < n_q))
		else $error("round counter past vertex count");

	// finishing a run clears the edge count and offers a result beat
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == S_LOAD && cnt_q == '0 && res_valid_q))
		else $error("run did not finish cleanly");
endmodule

// ----- tb/tb_longest_path_bellman_ford.sv -----
// self-checking testbench for the longest path block: drives edge graphs and
// vertex counts, predicts each graph's result and compares every result beat
// depends on lbf_pkg, lbf_edge_if, lbf_result_if and longest_path_bellman_ford
module tb_longest_path_bellman_ford;

	typedef struct {
		logic [lbf_pkg::STATUS_W-1:0]      status;
		logic signed [lbf_pkg::DIST_W-1:0] distance;
	} path_result_t;

	class path_scoreboard;
		bit [lbf_pkg::VID_W-1:0]  src_q[$];
		bit [lbf_pkg::VID_W-1:0]  dst_q[$];
		longint                   wgt_q[$];
		bit [lbf_pkg::CFG_W-1:0]  vertex_cfg = 1;
		path_result_t             expected_q[$];
		int                       errors = 0;

		function void note_edge(bit [lbf_pkg::VID_W-1:0] a, bit [lbf_pkg::VID_W-1:0] b,
				logic signed [lbf_pkg::WEIGHT_W-1:0] w, bit last);
			int n;
			int k;
			int r;
			longint cand;
			longint best_d[lbf_pkg::MAX_VERTICES_DEF];
			bit reach[lbf_pkg::MAX_VERTICES_DEF];
			bit unb[lbf_pkg::MAX_VERTICES_DEF];
			path_result_t res;
			if (src_q.size() < lbf_pkg::MAX_EDGES_DEF) begin
				src_q.insert(src_q.size(), a);
				dst_q.insert(dst_q.size(), b);
				wgt_q.insert(wgt_q.size(), longint'(w));
			end
			if (!last)
				return;
			n = (vertex_cfg == 0) ? 1 : (vertex_cfg > lbf_pkg::MAX_VERTICES_DEF)
				? lbf_pkg::MAX_VERTICES_DEF : int'(vertex_cfg);
			foreach (reach[i]) begin
				reach[i] = 0;
				unb[i] = 0;
				best_d[i] = 0;
			end
			reach[0] = 1;
			// n relaxation rounds, then one marking round
			for (r = 0; r <= n; r++) begin
				for (k = 0; k < src_q.size(); k++) begin
					if (src_q[k] >= n || dst_q[k] >= n || !reach[src_q[k]])
						continue;
					cand = best_d[src_q[k]] + wgt_q[k];
					if (reach[dst_q[k]] && cand <= best_d[dst_q[k]])
						continue;
					if (r == n) begin
						unb[dst_q[k]] = 1;
						continue;
					end
					if (cand > longint'(lbf_pkg::DIST_MAX)) begin
						cand = longint'(lbf_pkg::DIST_MAX);
						unb[dst_q[k]] = 1;
					end
					if (cand < longint'(lbf_pkg::DIST_MIN))
						cand = longint'(lbf_pkg::DIST_MIN);
					if (!reach[dst_q[k]] || cand > best_d[dst_q[k]]) begin
						best_d[dst_q[k]] = cand;
						reach[dst_q[k]] = 1;
					end
				end
			end
			for (r = 0; r < n; r++)
				for (k = 0; k < src_q.size(); k++)
					if (src_q[k] < n && dst_q[k] < n && reach[src_q[k]] && unb[src_q[k]])
						unb[dst_q[k]] = 1;
			if (!reach[n-1]) begin
				res.status = lbf_pkg::ST_UNREACH;
				res.distance = '0;
			end else if (unb[n-1]) begin
				res.status = lbf_pkg::ST_UNBOUNDED;
				res.distance = '0;
			end else begin
				res.status = lbf_pkg::ST_FINITE;
				res.distance = best_d[n-1][lbf_pkg::DIST_W-1:0];
			end
			expected_q.insert(expected_q.size(), res);
			src_q.delete();
			dst_q.delete();
			wgt_q.delete();
		endfunction

		function void check_result(logic [lbf_pkg::STATUS_W-1:0] st,
				logic signed [lbf_pkg::DIST_W-1:0] d);
			path_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d distance=%0d", $time, st, d);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (st !== e.status) begin
				$display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (d !== e.distance) begin
				$display("%0t: distance mismatch expected %0d actual %0d", $time,
					e.distance, d);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lbf_pkg::CFG_W-1:0] cfg_wdata;
	int send_idle;
	int recv_idle;
	int sent;
	path_scoreboard sb;

	lbf_edge_if   edges_if();
	lbf_result_if result_if();

	longest_path_bellman_ford u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.edges     (edges_if),
		.result    (result_if)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#36000000;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk)
		result_if.ready = ($urandom_range(99) >= recv_idle);

	always @(posedge clk)
		if (arst_n && result_if.valid && result_if.ready)
			sb.check_result(result_if.status, result_if.longest_distance);

	task automatic send_edge(int a, int b, logic signed [lbf_pkg::WEIGHT_W-1:0] w, bit last);
		while ($urandom_range(99) < send_idle) begin
			edges_if.valid = 0;
			@(negedge clk);
		end
		edges_if.valid = 1;
		edges_if.edge_from = a[lbf_pkg::VID_W-1:0];
		edges_if.edge_to = b[lbf_pkg::VID_W-1:0];
		edges_if.edge_weight = w;
		edges_if.last_edge = last;
		do @(posedge clk); while (!edges_if.ready);
		sb.note_edge(a[lbf_pkg::VID_W-1:0], b[lbf_pkg::VID_W-1:0], w, last);
		sent++;
		@(negedge clk);
	endtask

	// waits until every predicted result has been checked, then writes the vertex count
	task automatic set_vertices(int n);
		edges_if.valid = 0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = n[lbf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we = 0;
		sb.vertex_cfg = n[lbf_pkg::CFG_W-1:0];
	endtask

	task automatic random_graph(int n_eff);
		int cnt;
		int i;
		int extra;
		logic signed [lbf_pkg::WEIGHT_W-1:0] w;
		// spine of edges from vertex i to i+1, starting at vertex 0, leads towards the target
		cnt = (n_eff > 32) ? 2 : $urandom_range(n_eff + 3, 1);
		for (i = 0; i < cnt; i++) begin
			extra = $urandom_range(99);
			w = (extra < 80) ? $signed($urandom_range(40)) - 25 : $urandom;
			if (extra < 60 && i < n_eff - 1)
				send_edge(i, i + 1, w, i == cnt - 1);
			else if (extra < 92)
				send_edge($urandom_range(n_eff - 1), $urandom_range(n_eff - 1), w,
					i == cnt - 1);
			else
				send_edge($urandom_range(255), $urandom_range(255), w, i == cnt - 1);
		end
	endtask

	initial begin
		int g;
		int n_eff;
		int ncfg;
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		send_idle = 28;
		recv_idle = 81;
		sent = 0;
		result_if.ready = 0;
		edges_if.valid = 0;
		edges_if.edge_from = '0;
		edges_if.edge_to = '0;
		edges_if.edge_weight = '0;
		edges_if.last_edge = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset vertex count: self loop on the target
		send_edge(0, 0, 5, 1);
		send_edge(3, 4, 9, 1);
		set_vertices(2);
		send_edge(0, 1, 32'sh7fffffff, 1);
		send_edge(0, 1, 32'sh80000000, 1);
		send_edge(1, 0, 5, 1);
		send_edge(0, 1, 3, 0);
		send_edge(1, 0, -1, 1);
		send_edge(0, 1, 3, 0);
		send_edge(1, 0, -3, 1);
		set_vertices(0);
		send_edge(0, 0, -1, 1);
		set_vertices(511);
		send_edge(0, 255, 7, 0);
		send_edge(255, 255, -7, 1);
		set_vertices(256);
		send_edge(0, 255, -1, 1);
		set_vertices(3);
		send_edge(0, 1, 10, 0);
		send_edge(1, 2, -4, 0);
		send_edge(0, 2, 5, 0);
		send_edge(2, 1, -20, 1);
		// full edge store, last edge dropped
		set_vertices(1);
		for (int i = 0; i < lbf_pkg::MAX_EDGES_DEF; i++)
			send_edge($urandom_range(255), $urandom_range(255), $urandom, 0);
		send_edge(0, 0, 1, 1);

		n_eff = 1;
		for (g = 0; sent < 1800; g++) begin
			if (sent < 1300) begin
				send_idle = 28;
				recv_idle = 81;
			end else if (sent < 1550) begin
				send_idle = 81;
				recv_idle = 28;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if ($urandom_range(99) < 20) begin
				ncfg = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(12, 1);
				set_vertices(ncfg);
				n_eff = (ncfg == 0) ? 1 : (ncfg > 256) ? 256 : ncfg;
			end
			random_graph(n_eff);
		end

		edges_if.valid = 0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
design/lbf_pkg.sv
design/lbf_edge_if.sv
design/lbf_result_if.sv
design/lbf_ram.sv
design/longest_path_bellman_ford.sv
tb/tb_longest_path_bellman_ford.sv
